// ===== rtl/wls_pkg.sv =====
// Package for the weighted link selector: field widths, configuration record,
// queue entry layout and divider request/response records.
// No dependencies; every other file of the block imports it.
package wls_pkg;

  localparam int RTT_W    = 16;
  localparam int LOSS_W   = 14;
  localparam int THR_W    = 20;
  localparam int WEIGHT_W = 17;
  localparam int SCORE_W  = 18;
  localparam int TIME_W   = 32;
  localparam int NUM_W    = 20;
  localparam int QUAL_W   = 17;
  localparam int PROD_W   = 34;
  localparam int ACC_W    = 34;
  localparam int DIV_BITS = 16;
  localparam int DIV_BITS_PER_CYCLE = 2;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int NUM_METRICS   = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RTT_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W_RTT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_LOSS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W_THR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL      = 3'd7;

  // Quality of one as a Q1.16 value and the largest possible score.
  localparam logic [QUAL_W-1:0]  QUAL_ONE  = 17'h10000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 18'd196608;

  typedef struct packed {
    logic [RTT_W-1:0]    rtt_limit;
    logic [LOSS_W-1:0]   loss_limit;
    logic [THR_W-1:0]    thr_limit;
    logic [WEIGHT_W-1:0] w_rtt;
    logic [WEIGHT_W-1:0] w_loss;
    logic [WEIGHT_W-1:0] w_thr;
    logic [SCORE_W-1:0]  margin;
    logic [TIME_W-1:0]   dwell;
  } cfg_t;

  typedef enum logic [1:0] {
    Q_ZERO = 2'd0,
    Q_FULL = 2'd1,
    Q_DIV  = 2'd2
  } qkind_t;

  typedef struct packed {
    qkind_t           kind;
    logic [NUM_W-1:0] num;
  } metric_t;

  // Metrics 0..2 belong to the primary link (rtt, loss, throughput),
  // metrics 3..5 to the secondary link in the same order.
  typedef struct packed {
    logic                         a_avail;
    logic                         b_avail;
    metric_t [NUM_METRICS-1:0]    metrics;
    logic [TIME_W-1:0]            time_ms;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DIV_BITS-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/wls_front.sv =====
// Front end of the link selector: takes input transfers, classifies each of
// the six qualities and holds the result in a short queue. Uses wls_pkg.
module wls_front
  import wls_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_DATA_W-1:0] in_data,
  input  cfg_t                 cfg,
  input  logic                 pop,
  output logic                 item_valid,
  output item_t                item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Falling quality: zero at or beyond the limit, full at zero, otherwise
  // (lim - v) / lim. A zero metric would give a quotient of exactly one,
  // which the divider cannot produce, so it is classified as full.
  function automatic metric_t falling(input logic [NUM_W-1:0] v,
                                      input logic [NUM_W-1:0] lim);
    metric_t m;
    m.num = lim - v;
    if (lim == '0 || v >= lim) m.kind = Q_ZERO;
    else if (v == '0) m.kind = Q_FULL;
    else m.kind = Q_DIV;
    return m;
  endfunction

  // Rising quality: zero for a zero limit, full at or beyond a nonzero limit, otherwise v / lim.
  function automatic metric_t rising(input logic [NUM_W-1:0] v,
                                     input logic [NUM_W-1:0] lim);
    metric_t m;
    m.num = v;
    if (lim == '0) m.kind = Q_ZERO;
    else if (v >= lim) m.kind = Q_FULL;
    else m.kind = Q_DIV;
    return m;
  endfunction

  item_t             queue_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  item_t             cls;
  logic              push;
  logic              do_pop;

  always_comb begin
    logic [NUM_W-1:0] rlim, llim, tlim;
    rlim = NUM_W'(cfg.rtt_limit);
    llim = NUM_W'(cfg.loss_limit);
    tlim = cfg.thr_limit;
    cls.a_avail    = in_data[0];
    cls.metrics[0] = falling(NUM_W'(in_data[16:1]), rlim);
    cls.metrics[1] = falling(NUM_W'(in_data[30:17]), llim);
    cls.metrics[2] = rising(in_data[50:31], tlim);
    cls.b_avail    = in_data[51];
    cls.metrics[3] = falling(NUM_W'(in_data[67:52]), rlim);
    cls.metrics[4] = falling(NUM_W'(in_data[81:68]), llim);
    cls.metrics[5] = rising(in_data[101:82], tlim);
    cls.time_ms    = in_data[133:102];
  end

  assign in_ready   = (count_r != CNT_FULL);
  assign item_valid = (count_r != '0);
  assign item       = queue_mem[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && item_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop) rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) queue_mem[wr_ptr_r] <= cls;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_FULL) && !do_pop |=> count_r == CNT_FULL)
    else $error("full queue lost an entry");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ===== rtl/wls_div.sv =====
// Shared restoring divider of the link selector: 16 quotient bits of
// (num << 16) / den, two bits per cycle, for num below den. Uses wls_pkg.
module wls_div
  import wls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int REM_W  = NUM_W + 1;
  localparam int ITERS  = DIV_BITS / DIV_BITS_PER_CYCLE;
  localparam int CNT_W  = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITERS - 1);

  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]    den_r;
  logic [DIV_BITS-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;

  always_comb begin
    logic [REM_W-1:0] t;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      t = {rem_nxt[REM_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t = t - {1'b0, den_r};
        quot_nxt = {quot_nxt[DIV_BITS-2:0], 1'b1};
      end else begin
        quot_nxt = {quot_nxt[DIV_BITS-2:0], 1'b0};
      end
      rem_nxt = t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= {1'b0, req.num};
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== rtl/wls_back.sv =====
// Back end of the link selector: sequences the six qualities (divisions via
// the shared divider), forms the weighted scores, runs the hysteresis and
// dwell decision and holds the result register. Uses wls_pkg and wls_div.
module wls_back
  import wls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  item_valid,
  input  item_t                 item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_ACC  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  localparam logic [1:0] MK_RTT  = 2'd0;
  localparam logic [1:0] MK_LOSS = 2'd1;
  localparam logic [1:0] MK_THR  = 2'd2;

  state_t               state_r, state_nxt;
  logic                 link_r;
  logic [1:0]           mk_r;
  logic [QUAL_W-1:0]    qual_r;
  logic [PROD_W-1:0]    prod_r;
  logic [ACC_W-1:0]     acc_r;
  logic [SCORE_W-1:0]   sa_r;
  logic                 active_r;
  logic                 timing_r;
  logic [TIME_W-1:0]    start_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 chosen_r;
  logic [SCORE_W-1:0]   out_sa_r;
  logic [SCORE_W-1:0]   out_sb_r;
  logic                 switched_r;

  div_req_t             div_req;
  div_rsp_t             div_rsp;
  metric_t              cur_metric;
  logic [NUM_W-1:0]     cur_den;
  logic [WEIGHT_W-1:0]  cur_w_raw;
  logic [WEIGHT_W-1:0]  cur_w;
  logic [2:0]           metric_idx;
  logic [ACC_W-1:0]     acc_sum;
  logic [SCORE_W-1:0]   sum_score;
  logic [SCORE_W-1:0]   sb_final;
  logic                 emit_fire;
  logic [SCORE_W-1:0]   score_cur, score_other;
  logic                 better;
  logic [TIME_W-1:0]    elapsed;
  logic                 switch_now;

  wls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign metric_idx = link_r ? (3'(mk_r) + 3'd3) : 3'(mk_r);
  assign cur_metric = item.metrics[metric_idx];

  always_comb begin
    unique case (mk_r)
      MK_RTT: begin
        cur_den   = NUM_W'(cfg.rtt_limit);
        cur_w_raw = cfg.w_rtt;
      end
      MK_LOSS: begin
        cur_den   = NUM_W'(cfg.loss_limit);
        cur_w_raw = cfg.w_loss;
      end
      MK_THR: begin
        cur_den   = cfg.thr_limit;
        cur_w_raw = cfg.w_thr;
      end
      default: begin
        cur_den   = '0;
        cur_w_raw = '0;
      end
    endcase
  end

  // Weights above one count as one.
  assign cur_w = cur_w_raw[WEIGHT_W-1] ? QUAL_ONE : cur_w_raw;

  assign div_req.start = (state_r == S_LOAD) && (cur_metric.kind == Q_DIV);
  assign div_req.num   = cur_metric.num;
  assign div_req.den   = cur_den;

  assign acc_sum   = acc_r + prod_r;
  assign sum_score = acc_sum[ACC_W-1:16];
  // By the emit state the accumulator already holds the whole secondary sum.
  assign sb_final  = item.b_avail ? acc_r[ACC_W-1:16] : '0;

  // Hysteresis and dwell decision on the finished pair of scores.
  assign score_cur   = active_r ? sb_final : sa_r;
  assign score_other = active_r ? sa_r : sb_final;
  assign better      = {1'b0, score_other} > ({1'b0, score_cur} + {1'b0, cfg.margin});
  assign elapsed     = item.time_ms - start_r;
  assign switch_now  = better && timing_r && (elapsed >= cfg.dwell);

  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign pop       = emit_fire;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (item_valid) state_nxt = S_LOAD;
      S_LOAD: state_nxt = (cur_metric.kind == Q_DIV) ? S_DIV : S_MUL;
      S_DIV:  if (div_rsp.done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = (mk_r == MK_THR && link_r) ? S_EMIT : S_LOAD;
      S_EMIT: if (emit_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      timing_r    <= 1'b0;
      start_r     <= '0;
      link_r      <= 1'b0;
      mk_r        <= MK_RTT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_IDLE) begin
        link_r <= 1'b0;
        mk_r   <= MK_RTT;
      end else if (state_r == S_ACC) begin
        if (mk_r == MK_THR) begin
          mk_r   <= MK_RTT;
          link_r <= 1'b1;
        end else begin
          mk_r <= mk_r + 1'b1;
        end
      end
      if (emit_fire) begin
        if (!better) begin
          timing_r <= 1'b0;
          start_r  <= '0;
        end else if (!timing_r) begin
          timing_r <= 1'b1;
          start_r  <= item.time_ms;
        end else if (switch_now) begin
          active_r <= !active_r;
          timing_r <= 1'b0;
          start_r  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) acc_r <= '0;
    if (state_r == S_LOAD && cur_metric.kind != Q_DIV)
      qual_r <= (cur_metric.kind == Q_FULL) ? QUAL_ONE : '0;
    if (state_r == S_DIV && div_rsp.done) qual_r <= {1'b0, div_rsp.quot};
    if (state_r == S_MUL) prod_r <= cur_w * qual_r;
    if (state_r == S_ACC) begin
      if (mk_r == MK_THR && !link_r) begin
        sa_r  <= item.a_avail ? sum_score : '0;
        acc_r <= '0;
      end else begin
        acc_r <= acc_sum;
      end
    end
    if (emit_fire) begin
      chosen_r   <= active_r ^ switch_now;
      out_sa_r   <= sa_r;
      out_sb_r   <= sb_final;
      switched_r <= switch_now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {2'b00, switched_r, out_sb_r, out_sa_r, chosen_r};

`ifndef SYNTHESIS
  a_rise_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pop))
    else $error("result appeared without a finished item");
  a_switch_flip: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && switch_now |=> active_r != $past(active_r))
    else $error("switch reported without a change of link");
  a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    !timing_r |-> start_r == '0)
    else $error("start time kept while not timing");
  a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sa_r <= SCORE_MAX) && (out_sb_r <= SCORE_MAX))
    else $error("score above three");
  a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");
`endif

endmodule

// ===== rtl/weighted_link_selector_unit.sv =====
// Top level of the weighted link selector: configuration registers, the
// classifying front end with its queue, and the scoring back end.
// Depends on wls_pkg, wls_front and wls_back.
//
//   Channel   Direction  Handshake              Payload
//   in_       slave      in_tvalid / in_tready  in_tdata, 136 bits, link metrics
//   out_      master     out_tvalid/out_tready  out_tdata, 40 bits, choice and scores
//   cfg_      write      cfg_we                 cfg_index, cfg_wdata
//
// An item passes from the queue to the result register through a start step,
// then for each of the six qualities a setup, a wait on the shared
// two-bit-per-cycle divider when it needs one, a multiply and an accumulate,
// and finally the step that issues the result; a zero or full quality skips
// the divider.
// Reset (rst_n low at a clock edge) empties the queue, clears the decision
// state and restores the register defaults; no clearing pass follows.
// A stalled output holds the result register while the front end keeps
// accepting transfers until its queue is full.
module weighted_link_selector_unit
  import wls_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Fields from bit 0 up: a_available, a_rtt_ms, a_loss, a_throughput,
  // b_available, b_rtt_ms, b_loss, b_throughput, time_ms, two zero bits.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0 up: chosen_link, a_score, b_score, switched,
  // two zero bits.
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg_r, cfg_nxt;
  logic  item_valid;
  item_t item;
  logic  pop;

  // Register writes; each value is cut to its register's width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_RTT_LIMIT:  cfg_nxt.rtt_limit  = cfg_wdata[RTT_W-1:0];
        REG_LOSS_LIMIT: cfg_nxt.loss_limit = cfg_wdata[LOSS_W-1:0];
        REG_THR_LIMIT:  cfg_nxt.thr_limit  = cfg_wdata[THR_W-1:0];
        REG_W_RTT:      cfg_nxt.w_rtt      = cfg_wdata[WEIGHT_W-1:0];
        REG_W_LOSS:     cfg_nxt.w_loss     = cfg_wdata[WEIGHT_W-1:0];
        REG_W_THR:      cfg_nxt.w_thr      = cfg_wdata[WEIGHT_W-1:0];
        REG_MARGIN:     cfg_nxt.margin     = cfg_wdata[SCORE_W-1:0];
        REG_DWELL:      cfg_nxt.dwell      = cfg_wdata[TIME_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rtt_limit  <= 16'd1000;
      cfg_r.loss_limit <= 14'd10000;
      cfg_r.thr_limit  <= 20'd100000;
      cfg_r.w_rtt      <= 17'd21845;
      cfg_r.w_loss     <= 17'd21845;
      cfg_r.w_thr      <= 17'd21846;
      cfg_r.margin     <= 18'd3277;
      cfg_r.dwell      <= 32'd2000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end classifies every quality as zero, full or a division
  // and queues the item; the back end works through it.
  wls_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .cfg        (cfg_r),
    .pop        (pop),
    .item_valid (item_valid),
    .item       (item)
  );

  wls_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule
